[rtl/wsad_pkg.sv]
// ----------------------------------------------------------------------------
// wsad_pkg
// Shared constants and control types of the window statistics detector.
// ----------------------------------------------------------------------------
`default_nettype none
package wsad_pkg;

   localparam int WINDOW_MAX = 128;
   localparam int ADDR_BITS  = $clog2(WINDOW_MAX);
   localparam int FILL_BITS  = ADDR_BITS + 1;
   localparam int SAMPLE_W   = 16;
   localparam int DIV_STEPS  = 45;
   localparam int CNT_BITS   = 6;
   localparam int RSP_W      = 56;

   // configuration register indexes
   localparam logic [3:0] REG_WINDOW_LEN  = 4'd0;
   localparam logic [3:0] REG_MIN_SAMPLES = 4'd1;
   localparam logic [3:0] REG_LOWER_LIMIT = 4'd2;
   localparam logic [3:0] REG_UPPER_LIMIT = 4'd3;
   localparam logic [3:0] REG_RUN_LIMIT   = 4'd4;
   localparam logic [3:0] REG_CUSUM_SLACK = 4'd5;
   localparam logic [3:0] REG_CUSUM_LIMIT = 4'd6;
   localparam logic [3:0] REG_SIGMA_K     = 4'd7;

   typedef struct packed {
      logic load_x;
      logic drop_rd;
      logic drop_sq;
      logic drop_sub;
      logic push_sq;
      logic push;
      logic mul1;
      logic mul2;
      logic mul3;
      logic mul4;
      logic div_step;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic drop_needed;
   } sts_type;

endpackage
`default_nettype wire

[rtl/wsad_ctrl.sv]
// ----------------------------------------------------------------------------
// wsad_ctrl
// Sequencer: window trim, push, product steps, divide steps, result load.
// ----------------------------------------------------------------------------
`default_nettype none
module wsad_ctrl import wsad_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DCHK = 4'd1;
   localparam logic [3:0] S_DRD  = 4'd2;
   localparam logic [3:0] S_DSQ  = 4'd3;
   localparam logic [3:0] S_DSUB = 4'd4;
   localparam logic [3:0] S_PSQ  = 4'd5;
   localparam logic [3:0] S_PUSH = 4'd6;
   localparam logic [3:0] S_M1   = 4'd7;
   localparam logic [3:0] S_M2   = 4'd8;
   localparam logic [3:0] S_M3   = 4'd9;
   localparam logic [3:0] S_M4   = 4'd10;
   localparam logic [3:0] S_DIV  = 4'd11;
   localparam logic [3:0] S_FIN  = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                valid_ff, valid_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_x = 1'b1;
               state_in   = S_DCHK;
            end
         end
         S_DCHK: state_in = sts.drop_needed ? S_DRD : S_PSQ;
         S_DRD: begin
            cmd.drop_rd = 1'b1;
            state_in    = S_DSQ;
         end
         S_DSQ: begin
            cmd.drop_sq = 1'b1;
            state_in    = S_DSUB;
         end
         S_DSUB: begin
            cmd.drop_sub = 1'b1;
            state_in     = S_DCHK;
         end
         S_PSQ: begin
            cmd.push_sq = 1'b1;
            state_in    = S_PUSH;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_M1;
         end
         S_M1: begin
            cmd.mul1 = 1'b1;
            state_in = S_M2;
         end
         S_M2: begin
            cmd.mul2 = 1'b1;
            state_in = S_M3;
         end
         S_M3: begin
            cmd.mul3 = 1'b1;
            state_in = S_M4;
         end
         S_M4: begin
            cmd.mul4 = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // wait for the output register to drain
            if (!valid_ff || rsp_tready) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.fin) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule
`default_nettype wire

[rtl/wsad_dp.sv]
// ----------------------------------------------------------------------------
// wsad_dp
// Datapath: config registers, sample ring, running sums, products,
// two restoring dividers, range run, CUSUM and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module wsad_dp import wsad_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [3:0]          csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic [SAMPLE_W-1:0] req_tdata,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   output logic [RSP_W-1:0]         rsp_tdata
);

   // configuration
   logic [7:0]         win_len_ff, win_len_in;
   logic [7:0]         min_smp_ff, min_smp_in;
   logic signed [15:0] lower_ff, lower_in;
   logic signed [15:0] upper_ff, upper_in;
   logic [3:0]         run_lim_ff, run_lim_in;
   logic [14:0]        slack_ff, slack_in;
   logic [15:0]        climit_ff, climit_in;
   logic [7:0]         sigk_ff, sigk_in;

   always_comb begin
      win_len_in = win_len_ff;
      min_smp_in = min_smp_ff;
      lower_in   = lower_ff;
      upper_in   = upper_ff;
      run_lim_in = run_lim_ff;
      slack_in   = slack_ff;
      climit_in  = climit_ff;
      sigk_in    = sigk_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_WINDOW_LEN:  win_len_in = csr_wdata[7:0];
            REG_MIN_SAMPLES: min_smp_in = csr_wdata[7:0];
            REG_LOWER_LIMIT: lower_in   = $signed(csr_wdata);
            REG_UPPER_LIMIT: upper_in   = $signed(csr_wdata);
            REG_RUN_LIMIT:   run_lim_in = csr_wdata[3:0];
            REG_CUSUM_SLACK: slack_in   = csr_wdata[14:0];
            REG_CUSUM_LIMIT: climit_in  = csr_wdata;
            REG_SIGMA_K:     sigk_in    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= 8'd100;
         min_smp_ff <= 8'd20;
         lower_ff   <= 16'sd0;
         upper_ff   <= 16'sd1360;
         run_lim_ff <= 4'd3;
         slack_ff   <= 15'd3;
         climit_ff  <= 16'd80;
         sigk_ff    <= 8'd48;
      end else begin
         win_len_ff <= win_len_in;
         min_smp_ff <= min_smp_in;
         lower_ff   <= lower_in;
         upper_ff   <= upper_in;
         run_lim_ff <= run_lim_in;
         slack_ff   <= slack_in;
         climit_ff  <= climit_in;
         sigk_ff    <= sigk_in;
      end
   end

   // effective window length
   logic [FILL_BITS-1:0] len_eff;
   always_comb begin
      if (win_len_ff == 8'd0) begin
         len_eff = FILL_BITS'(1);
      end else if (win_len_ff > 8'(WINDOW_MAX)) begin
         len_eff = FILL_BITS'(WINDOW_MAX);
      end else begin
         len_eff = FILL_BITS'(win_len_ff);
      end
   end

   // window state
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] old_ff;
   logic [ADDR_BITS-1:0]       slot_ff, slot_in;
   logic [FILL_BITS-1:0]       fill_ff, fill_in;
   logic signed [23:0]         sum_ff, sum_in;
   logic [37:0]                sumsq_ff, sumsq_in;
   logic [31:0]                sq_ff, sq_in;
   logic [ADDR_BITS-1:0]       oldest;
   logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];

   assign oldest          = slot_ff - fill_ff[ADDR_BITS-1:0];
   assign sts.drop_needed = fill_ff >= len_eff;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         ring_mem[slot_ff] <= x_ff;
      end
      if (cmd.drop_rd) begin
         old_ff <= ring_mem[oldest];
      end
   end

   always_comb begin
      x_in     = cmd.load_x ? $signed(req_tdata) : x_ff;
      sq_in    = sq_ff;
      slot_in  = slot_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      if (cmd.drop_sq) begin
         sq_in = 32'(old_ff * old_ff);
      end
      if (cmd.push_sq) begin
         sq_in = 32'(x_ff * x_ff);
      end
      if (cmd.drop_sub) begin
         sum_in   = sum_ff - 24'(old_ff);
         sumsq_in = sumsq_ff - 38'(sq_ff);
         fill_in  = fill_ff - 1'b1;
      end
      if (cmd.push) begin
         sum_in   = sum_ff + 24'(x_ff);
         sumsq_in = sumsq_ff + 38'(sq_ff);
         fill_in  = fill_ff + 1'b1;
         slot_in  = slot_ff + 1'b1;
      end
   end

   // product steps
   logic [45:0]        pa_ff, pa_in, pb_ff, pb_in;
   logic [22:0]        smag_ff, smag_in;
   logic [14:0]        n2_ff, n2_in;
   logic signed [23:0] nx_ff, nx_in;
   logic [44:0]        d_ff, d_in;
   logic [23:0]        dev_ff, dev_in;
   logic [15:0]        k2_ff, k2_in;
   logic [47:0]        lhs_ff, lhs_in;
   logic [38:0]        rlo_ff, rlo_in;
   logic [60:0]        rhs_ff, rhs_in;
   logic signed [24:0] devs;
   logic [22:0]        smag_c;

   assign smag_c = sum_ff[23] ? 23'(24'sd0 - sum_ff) : sum_ff[22:0];
   assign devs   = 25'(nx_ff) - 25'(sum_ff);

   always_comb begin
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      smag_in = smag_ff;
      n2_in   = n2_ff;
      nx_in   = nx_ff;
      d_in    = d_ff;
      dev_in  = dev_ff;
      k2_in   = k2_ff;
      lhs_in  = lhs_ff;
      rlo_in  = rlo_ff;
      rhs_in  = rhs_ff;
      if (cmd.mul1) begin
         pa_in   = 46'(fill_ff) * 46'(sumsq_ff);
         pb_in   = 46'(smag_c) * 46'(smag_c);
         smag_in = smag_c;
         n2_in   = 15'(16'(fill_ff) * 16'(fill_ff));
         nx_in   = 24'($signed({1'b0, fill_ff}) * x_ff);
      end
      if (cmd.mul2) begin
         d_in   = 45'(pa_ff - pb_ff);
         dev_in = devs[24] ? 24'(25'sd0 - devs) : devs[23:0];
         k2_in  = 16'(sigk_ff) * 16'(sigk_ff);
      end
      if (cmd.mul3) begin
         lhs_in = 48'(dev_ff) * 48'(dev_ff);
         rlo_in = 39'(k2_ff) * 39'(d_ff[22:0]);
      end
      if (cmd.mul4) begin
         rhs_in = ((61'(k2_ff) * 61'(d_ff[44:23])) << 23) + 61'(rlo_ff);
      end
   end

   // restoring dividers, one quotient bit per step
   logic [44:0] nv_ff, nv_in, nm_ff, nm_in;
   logic [15:0] rv_ff, rv_in, rm_ff, rm_in;
   logic [16:0] tv, tm;

   assign tv = {rv_ff, nv_ff[44]} - 17'(n2_ff);
   assign tm = {rm_ff, nm_ff[44]} - 17'(fill_ff);

   always_comb begin
      nv_in = nv_ff;
      rv_in = rv_ff;
      nm_in = nm_ff;
      rm_in = rm_ff;
      if (cmd.mul4) begin
         nv_in = d_ff;
         rv_in = '0;
         nm_in = 45'(smag_ff);
         rm_in = '0;
      end
      if (cmd.div_step) begin
         if (!tv[16]) begin
            rv_in = tv[15:0];
            nv_in = {nv_ff[43:0], 1'b1};
         end else begin
            rv_in = {rv_ff[14:0], nv_ff[44]};
            nv_in = {nv_ff[43:0], 1'b0};
         end
         if (!tm[16]) begin
            rm_in = tm[15:0];
            nm_in = {nm_ff[43:0], 1'b1};
         end else begin
            rm_in = {rm_ff[14:0], nm_ff[44]};
            nm_in = {nm_ff[43:0], 1'b0};
         end
      end
   end

   // result stage
   logic [3:0]         run_ff, run_in;
   logic [19:0]        cup_ff, cup_in, cdn_ff, cdn_in;
   logic [RSP_W-1:0]   rsp_ff, rsp_in;
   logic signed [16:0] mean_w;
   logic signed [15:0] mean_c;
   logic signed [17:0] y;
   logic signed [22:0] up_c, dn_c;
   logic [19:0]        up_n, dn_n;
   logic               warm, sig, trend, range_hit, oor;
   logic [3:0]         run_n;

   always_comb begin
      // floor toward minus infinity for a negative sum
      if (sum_ff[23]) begin
         mean_w = 17'sd0 - $signed({1'b0, nm_ff[15:0]}) - ((rm_ff != 16'd0) ? 17'sd1 : 17'sd0);
      end else begin
         mean_w = $signed({1'b0, nm_ff[15:0]});
      end
      mean_c = mean_w[15:0];
      warm   = fill_ff >= FILL_BITS'(min_smp_ff);
      sig    = warm && (d_ff != 45'd0) && (61'({lhs_ff, 8'b0}) > rhs_ff);
      oor    = (x_ff < lower_ff) || (x_ff > upper_ff);
      if (oor) begin
         run_n = (run_ff == 4'd15) ? run_ff : run_ff + 1'b1;
      end else begin
         run_n = 4'd0;
      end
      range_hit = run_n >= run_lim_ff;
      y    = 18'(x_ff) - 18'(mean_c);
      up_c = $signed({3'b0, cup_ff}) + 23'(y) - $signed({8'b0, slack_ff});
      dn_c = $signed({3'b0, cdn_ff}) - 23'(y) - $signed({8'b0, slack_ff});
      up_n = (up_c > 23'sd0) ? up_c[19:0] : 20'd0;
      dn_n = (dn_c > 23'sd0) ? dn_c[19:0] : 20'd0;
      trend = 1'b0;
      cup_in = cup_ff;
      cdn_in = cdn_ff;
      run_in = run_ff;
      rsp_in = rsp_ff;
      if (cmd.fin) begin
         run_in = run_n;
         if (warm) begin
            if (up_n > 20'(climit_ff) || dn_n > 20'(climit_ff)) begin
               trend  = 1'b1;
               cup_in = '0;
               cdn_in = '0;
            end else begin
               cup_in = up_n;
               cdn_in = dn_n;
            end
         end
         rsp_in = {5'b0, nv_ff[30:0], mean_c, warm, trend, sig, range_hit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         run_ff   <= '0;
         cup_ff   <= '0;
         cdn_ff   <= '0;
      end else begin
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         sumsq_ff <= sumsq_in;
         run_ff   <= run_in;
         cup_ff   <= cup_in;
         cdn_ff   <= cdn_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      sq_ff   <= sq_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      smag_ff <= smag_in;
      n2_ff   <= n2_in;
      nx_ff   <= nx_in;
      d_ff    <= d_in;
      dev_ff  <= dev_in;
      k2_ff   <= k2_in;
      lhs_ff  <= lhs_in;
      rlo_ff  <= rlo_in;
      rhs_ff  <= rhs_in;
      nv_ff   <= nv_in;
      rv_ff   <= rv_in;
      nm_ff   <= nm_in;
      rm_ff   <= rm_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tdata = rsp_ff;

endmodule
`default_nettype wire

[rtl/window_stats_anomaly_detector_unit.sv]
// ----------------------------------------------------------------------------
// window_stats_anomaly_detector_unit
// Sliding-window mean/variance with range, sigma and CUSUM alarms.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one signed Q12.4 sample per word. rsp_ channel
//   returns one result word per sample: alarms, warm-up flag, floored mean
//   and floored population variance. csr_ writes one configuration
//   register per handshake; csr_ready is always high. Writes must go in
//   idle; the block itself does not enforce it. Each item passes the
//   window trim (one old sample trimmed in steady state, more after
//   window_len is lowered), the push, the product steps, the 45 one-bit
//   steps of the variance divider, which runs in parallel with the mean
//   divider, and the result load. req_tready is high only while the
//   sequencer idles, so the next word is taken in the cycle after the
//   result load.
//   One more item may be accepted while a result waits in the output
//   register; if the receiver stalls, the sequencer holds before loading
//   the next result. Reset clears window, sums, CUSUM and run counter and
//   loads the default register values; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module window_stats_anomaly_detector_unit import wsad_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [3:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,  // [15:0] sample
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [0] range_alarm [1] sigma_alarm [2] trend_alarm [3] warmed_up
   // [19:4] window_mean [50:20] window_variance [55:51] zero
   output logic [55:0]       rsp_tdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   wsad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   wsad_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

[rtl/wsad_checker.sv]
// ----------------------------------------------------------------------------
// wsad_checker
// Port-level assertions for the detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module wsad_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again while an item is at work");

   a_no_result_at_once: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result word appeared in the cycle after input");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[55:51] == 5'd0))
      else $error("padding bits of result word not zero");

endmodule

bind window_stats_anomaly_detector_unit wsad_checker u_wsad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
